@@ sv/cmes_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cmes_pkg
// Shared widths, constants and types for the complex minimum-energy search.
// ----------------------------------------------------------------------------
package cmes_pkg;

	localparam int SampleW          = 32;
	localparam int EnergyW          = 64;
	localparam int IndexW           = 12;
	localparam int ShiftW           = 6;
	localparam int MaxLenDefault    = 4096;
	localparam int FifoDepthDefault = 4;

	localparam logic [31:0] Uint32Max = 32'hFFFF_FFFF;

	typedef logic [EnergyW-1:0] energy_t;

	// one queue entry: energy of a sample and its end-of-vector mark
	typedef struct packed {
		energy_t energy;
		logic    last;
	} energy_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage
`default_nettype wire

@@ sv/cmes_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cmes_front
// Takes samples, forms magnitudes, squares them and pushes the energy into
// the queue. Two stages; the whole pipe holds while stage two waits on a full queue.
// ----------------------------------------------------------------------------
module cmes_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [cmes_pkg::SampleW-1:0] sample_real,
	input  wire logic [cmes_pkg::SampleW-1:0] sample_imag,
	input  wire logic                         last_sample,
	output logic                              push,
	output cmes_pkg::energy_item_t            push_item,
	input  wire cmes_pkg::queue_status_t      status
);

	logic                         valid_s1;
	logic [cmes_pkg::SampleW-1:0] mag_re_s1;
	logic [cmes_pkg::SampleW-1:0] mag_im_s1;
	logic                         last_s1;

	logic                         valid_s2;
	cmes_pkg::energy_t            sq_re_s2;
	cmes_pkg::energy_t            sq_im_s2;
	logic                         last_s2;

	logic                         adv;
	logic [cmes_pkg::SampleW-1:0] mag_re;
	logic [cmes_pkg::SampleW-1:0] mag_im;

	// -(-2^31) wraps to 0x8000_0000, which is the right unsigned magnitude
	assign mag_re = sample_real[cmes_pkg::SampleW-1] ? (~sample_real + 1'b1) : sample_real;
	assign mag_im = sample_imag[cmes_pkg::SampleW-1] ? (~sample_imag + 1'b1) : sample_imag;

	assign push     = valid_s2 && !status.full;
	assign adv      = !valid_s2 || !status.full;
	assign in_ready = adv;

	assign push_item.energy = sq_re_s2 + sq_im_s2;
	assign push_item.last   = last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_re_s1 <= mag_re;
			mag_im_s1 <= mag_im;
			last_s1   <= last_sample;
			sq_re_s2  <= cmes_pkg::EnergyW'(mag_re_s1) * cmes_pkg::EnergyW'(mag_re_s1);
			sq_im_s2  <= cmes_pkg::EnergyW'(mag_im_s1) * cmes_pkg::EnergyW'(mag_im_s1);
			last_s2   <= last_s1;
		end
	end

endmodule
`default_nettype wire

@@ sv/cmes_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cmes_fifo
// Short queue of energies between the front and the search back end.
// ----------------------------------------------------------------------------
module cmes_fifo #(
	parameter int DEPTH = cmes_pkg::FifoDepthDefault
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  wire cmes_pkg::energy_item_t  push_item,
	input  wire logic                    pop,
	output cmes_pkg::energy_item_t       pop_item,
	output cmes_pkg::queue_status_t      status
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	cmes_pkg::energy_item_t entries_q [DEPTH];
	logic [PtrW-1:0]        wr_ptr_q;
	logic [PtrW-1:0]        rd_ptr_q;
	logic [CntW-1:0]        count_q;

	assign pop_item     = entries_q[rd_ptr_q];
	assign status.full  = (count_q == CntFull);
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

@@ sv/cmes_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cmes_back
// Running minimum search over queued energies, then shift, saturate and
// hold the result in the output register.
// ----------------------------------------------------------------------------
module cmes_back #(
	parameter int MAX_LEN = cmes_pkg::MaxLenDefault
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cmes_pkg::queue_status_t      status,
	input  wire cmes_pkg::energy_item_t       head,
	output logic                              pop,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [cmes_pkg::ShiftW-1:0]  cfg_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [31:0]                       min_energy,
	output logic [cmes_pkg::IndexW-1:0]       min_index,
	output logic                              length_overflow
);

	localparam int PosW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CntW = $clog2(MAX_LEN + 1);
	localparam logic [CntW-1:0] CntMax  = CntW'(MAX_LEN);
	localparam logic [PosW-1:0] PosLast = PosW'(MAX_LEN - 1);

	logic [cmes_pkg::ShiftW-1:0] shift_q;

	// search state
	cmes_pkg::energy_t best_q;
	logic [PosW-1:0]   pos_q;
	logic [CntW-1:0]   cnt_q;
	logic              first_q;
	logic              ovf_q;

	// finished vector, before shifting
	logic              fin_valid_s1;
	cmes_pkg::energy_t fin_energy_s1;
	logic [PosW-1:0]   fin_pos_s1;
	logic              fin_ovf_s1;

	logic                        out_valid_q;
	logic [31:0]                 min_energy_q;
	logic [cmes_pkg::IndexW-1:0] min_index_q;
	logic                        length_overflow_q;

	logic                               out_free;
	logic                               fin_free;
	logic                               head_over;
	logic [PosW-1:0]                    pos_cur;
	logic                               take;
	cmes_pkg::energy_t                  best_new;
	logic [PosW-1:0]                    pos_new;
	logic                               ovf_new;
	cmes_pkg::energy_t                  shifted;
	logic [31:0]                        sat;
	logic [PosW+cmes_pkg::IndexW-1:0]   pos_wide;

	assign cfg_ready = 1'b1;

	assign out_free = !out_valid_q || out_ready;
	assign fin_free = !fin_valid_s1 || out_free;
	assign pop      = !status.empty && (!head.last || fin_free);

	assign head_over = (cnt_q >= CntMax);
	assign pos_cur   = head_over ? PosLast : cnt_q[PosW-1:0];
	// strict compare: on a tie the earlier sample stays
	assign take      = first_q || (head.energy < best_q);
	assign best_new  = take ? head.energy : best_q;
	assign pos_new   = take ? pos_cur : pos_q;
	assign ovf_new   = ovf_q || head_over;

	assign shifted  = fin_energy_s1 >> shift_q;
	assign sat      = (|shifted[cmes_pkg::EnergyW-1:32]) ? cmes_pkg::Uint32Max : shifted[31:0];
	assign pos_wide = {{cmes_pkg::IndexW{1'b0}}, fin_pos_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			shift_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q  <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			first_q <= 1'b1;
			ovf_q   <= 1'b0;
		end else if (pop) begin
			if (head.last) begin
				best_q  <= '0;
				pos_q   <= '0;
				cnt_q   <= '0;
				first_q <= 1'b1;
				ovf_q   <= 1'b0;
			end else begin
				best_q  <= best_new;
				pos_q   <= pos_new;
				cnt_q   <= head_over ? cnt_q : cnt_q + 1'b1;
				first_q <= 1'b0;
				ovf_q   <= ovf_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop && head.last) begin
				fin_valid_s1 <= 1'b1;
			end else if (out_free) begin
				fin_valid_s1 <= 1'b0;
			end
			if (fin_valid_s1 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			fin_energy_s1 <= best_new;
			fin_pos_s1    <= pos_new;
			fin_ovf_s1    <= ovf_new;
		end
		if (fin_valid_s1 && out_free) begin
			min_energy_q      <= sat;
			min_index_q       <= pos_wide[cmes_pkg::IndexW-1:0];
			length_overflow_q <= fin_ovf_s1;
		end
	end

	assign out_valid       = out_valid_q;
	assign min_energy      = min_energy_q;
	assign min_index       = min_index_q;
	assign length_overflow = length_overflow_q;

endmodule
`default_nettype wire

@@ sv/complex_min_energy_search_top.sv @@
`default_nettype none
// Path from the request carrying last_sample to out_valid: two front stages,
// queue, search update, shift/saturate register.
// Throughput: one sample per cycle; the front stalls only while the queue is
// full, which happens only while a result waits on out_ready.
// Reset: asynchronous, clears all control and search state and the shift setting.
// ----------------------------------------------------------------------------
// complex_min_energy_search_top
// Minimum-energy search over vectors of complex 32-bit samples.
// ----------------------------------------------------------------------------
module complex_min_energy_search_top #(
	parameter int MAX_LEN    = cmes_pkg::MaxLenDefault,
	parameter int FIFO_DEPTH = cmes_pkg::FifoDepthDefault
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [cmes_pkg::ShiftW-1:0]  cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [cmes_pkg::SampleW-1:0] sample_real,
	input  wire logic [cmes_pkg::SampleW-1:0] sample_imag,
	input  wire logic                         last_sample,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [31:0]                       min_energy,
	output logic [cmes_pkg::IndexW-1:0]       min_index,
	output logic                              length_overflow
);

	logic                    push;
	logic                    pop;
	cmes_pkg::energy_item_t  push_item;
	cmes_pkg::energy_item_t  head;
	cmes_pkg::queue_status_t status;

	cmes_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_real (sample_real),
		.sample_imag (sample_imag),
		.last_sample (last_sample),
		.push        (push),
		.push_item   (push_item),
		.status      (status)
	);

	cmes_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (head),
		.status    (status)
	);

	cmes_back #(
		.MAX_LEN (MAX_LEN)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.status          (status),
		.head            (head),
		.pop             (pop),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.min_energy      (min_energy),
		.min_index       (min_index),
		.length_overflow (length_overflow)
	);

endmodule
`default_nettype wire

@@ sv/cmes_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cmes_checker
// Port-level checks on the minimum-energy search, bound to the top level.
// ----------------------------------------------------------------------------
module cmes_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         cfg_valid,
	input wire logic                         cfg_ready,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [31:0]                  min_energy,
	input wire logic [cmes_pkg::IndexW-1:0]  min_index,
	input wire logic                         length_overflow
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(min_energy) && $stable(min_index)
			&& $stable(length_overflow))
		else $error("result changed while stalled");

	// input side only backs up behind a stalled result
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("input stalled without output back-pressure");

	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write refused");

endmodule

bind complex_min_energy_search_top cmes_checker u_cmes_checker (.*);
`default_nettype wire

@@ test/tb_complex_min_energy_search_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_complex_min_energy_search_top
// Drives vectors of complex samples into the minimum-energy search and checks
// every result against a local model of the search, or against the typed result
// of a hand-picked case. A short table of such cases runs first. Random vectors
// follow under several shift settings, with random gaps on both sides in all but
// one phase and one long output back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_complex_min_energy_search_top;

	localparam int MaxLen        = cmes_pkg::MaxLenDefault;
	localparam int NumPhases     = 5;
	localparam int ItemsPerPhase = 290;
	localparam int SettleCycles  = 12;
	localparam int HoldCycles    = 400;
	localparam int WatchdogLimit = 4000;
	localparam int NumRows       = 24;

	typedef struct packed {
		logic [31:0]                 energy;
		logic [cmes_pkg::IndexW-1:0] index;
		logic                        ovf;
	} search_result_t;

	typedef enum logic {ROW_SAMPLE, ROW_SHIFT} row_kind_t;

	typedef struct packed {
		row_kind_t                   kind;
		logic [31:0]                 re;
		logic [31:0]                 im;
		logic                        last;
		logic                        typed;
		logic [cmes_pkg::ShiftW-1:0] shift;
		search_result_t              result;
	} stim_row_t;

	// typed results apply to the shift setting in force at that row
	localparam stim_row_t DirectedRows [NumRows] = '{
		'{ROW_SAMPLE, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 6'd0, '{32'h0, 12'd0, 1'b0}},
		'{ROW_SAMPLE, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, 6'd0,
			'{32'hFFFF_FFFF, 12'd0, 1'b0}},
		'{ROW_SAMPLE, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 6'd0,
			'{32'hFFFF_FFFF, 12'd0, 1'b0}},
		'{ROW_SAMPLE, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 1'b1, 6'd0, '{32'd2, 12'd0, 1'b0}},
		'{ROW_SAMPLE, 32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 6'd0, '0},
		'{ROW_SAMPLE, 32'h0000_0003, 32'h0000_0004, 1'b0, 1'b0, 6'd0, '0},
		'{ROW_SAMPLE, 32'h0000_0000, 32'hFFFF_FFFB, 1'b0, 1'b0, 6'd0, '0},
		'{ROW_SAMPLE, 32'h0000_0001, 32'h0000_0001, 1'b1, 1'b1, 6'd0, '{32'd2, 12'd3, 1'b0}},
		// equal energies throughout: first position wins
		'{ROW_SAMPLE, 32'h0000_0003, 32'h0000_0004, 1'b0, 1'b0, 6'd0, '0},
		'{ROW_SAMPLE, 32'hFFFF_FFFC, 32'h0000_0003, 1'b0, 1'b0, 6'd0, '0},
		'{ROW_SAMPLE, 32'h0000_0005, 32'h0000_0000, 1'b1, 1'b1, 6'd0, '{32'd25, 12'd0, 1'b0}},
		'{ROW_SAMPLE, 32'h0000_0064, 32'h0000_0000, 1'b0, 1'b0, 6'd0, '0},
		'{ROW_SAMPLE, 32'hFFFF_FFF9, 32'h0000_0000, 1'b0, 1'b0, 6'd0, '0},
		'{ROW_SAMPLE, 32'h0000_0007, 32'h0000_0000, 1'b1, 1'b1, 6'd0, '{32'd49, 12'd1, 1'b0}},
		'{ROW_SAMPLE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, 6'd0, '0},
		'{ROW_SAMPLE, 32'h1234_5678, 32'hF89A_BCDF, 1'b1, 1'b0, 6'd0, '0},
		'{ROW_SHIFT,  32'h0, 32'h0, 1'b0, 1'b0, 6'd63, '0},
		'{ROW_SAMPLE, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, 6'd0, '{32'd1, 12'd0, 1'b0}},
		'{ROW_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 6'd0, '{32'd0, 12'd0, 1'b0}},
		'{ROW_SHIFT,  32'h0, 32'h0, 1'b0, 1'b0, 6'd32, '0},
		'{ROW_SAMPLE, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, 6'd0,
			'{32'h8000_0000, 12'd0, 1'b0}},
		'{ROW_SAMPLE, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 6'd0,
			'{32'h4000_0000, 12'd0, 1'b0}},
		'{ROW_SAMPLE, 32'hDEAD_BEEF, 32'h0BAD_F00D, 1'b1, 1'b0, 6'd0, '0},
		'{ROW_SHIFT,  32'h0, 32'h0, 1'b0, 1'b0, 6'd0, '0}
	};

	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        cfg_valid   = 1'b0;
	logic                        cfg_ready;
	logic [cmes_pkg::ShiftW-1:0] cfg_data    = '0;
	logic                        in_valid    = 1'b0;
	logic                        in_ready;
	logic [31:0]                 sample_real = '0;
	logic [31:0]                 sample_imag = '0;
	logic                        last_sample = 1'b0;
	logic                        out_valid;
	logic                        out_ready   = 1'b0;
	logic [31:0]                 min_energy;
	logic [cmes_pkg::IndexW-1:0] min_index;
	logic                        length_overflow;

	// travels with each request: use the typed result instead of the model's
	logic              row_typed   = 1'b0;
	search_result_t    row_result  = '0;

	logic              quiet       = 1'b0;
	logic              hold_req    = 1'b0;
	logic              hold_taken  = 1'b0;

	// local model of the search
	logic [cmes_pkg::ShiftW-1:0] shift_setting = '0;
	cmes_pkg::energy_t           best_energy   = '0;
	int                          best_pos      = 0;
	int                          vec_count     = 0;
	logic                        fresh         = 1'b1;
	logic                        ovf_seen      = 1'b0;

	search_result_t    expected_results [$];
	int                mismatch_count  = 0;
	int                results_checked = 0;
	int                samples_sent    = 0;
	int                shift_writes    = 0;

	complex_min_energy_search_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sample_real     (sample_real),
		.sample_imag     (sample_imag),
		.last_sample     (last_sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.min_energy      (min_energy),
		.min_index       (min_index),
		.length_overflow (length_overflow)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic cmes_pkg::energy_t part_power(input logic [31:0] v);
		logic [32:0] mag;
		mag = v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
		return cmes_pkg::energy_t'(mag) * cmes_pkg::energy_t'(mag);
	endfunction

	// one accepted sample; returns 1 when it closes a vector
	function automatic bit advance_search(input logic [31:0] re, input logic [31:0] im,
			input logic lst, output search_result_t res);
		cmes_pkg::energy_t e;
		cmes_pkg::energy_t shifted;
		int                pos;
		e = part_power(re) + part_power(im);
		if (vec_count >= MaxLen) begin
			ovf_seen = 1'b1;
			pos = MaxLen - 1;
		end else begin
			pos = vec_count;
			vec_count++;
		end
		if (fresh || e < best_energy) begin
			best_energy = e;
			best_pos = pos;
			fresh = 1'b0;
		end
		res = '0;
		if (!lst)
			return 1'b0;
		shifted = best_energy >> shift_setting;
		res.energy = (shifted > cmes_pkg::energy_t'(cmes_pkg::Uint32Max)) ?
			cmes_pkg::Uint32Max : shifted[31:0];
		res.index = best_pos[cmes_pkg::IndexW-1:0];
		res.ovf = ovf_seen;
		best_energy = '0;
		best_pos = 0;
		vec_count = 0;
		fresh = 1'b1;
		ovf_seen = 1'b0;
		return 1'b1;
	endfunction

	always @(posedge clk) begin : monitor
		search_result_t got;
		search_result_t want;
		search_result_t predicted;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{min_energy, min_index, length_overflow};
				results_checked++;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result energy %h index %0d overflow %b",
						$time, got.energy, got.index, got.ovf);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (got.energy !== want.energy) begin
						$display("%0t: min_energy expected %h actual %h",
							$time, want.energy, got.energy);
						mismatch_count++;
					end
					if (got.index !== want.index) begin
						$display("%0t: min_index expected %0d actual %0d",
							$time, want.index, got.index);
						mismatch_count++;
					end
					if (got.ovf !== want.ovf) begin
						$display("%0t: length_overflow expected %b actual %b",
							$time, want.ovf, got.ovf);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (advance_search(sample_real, sample_imag, last_sample, predicted))
					expected_results.push_back(row_typed ? row_result : predicted);
			end
			if (cfg_valid && cfg_ready)
				shift_setting = cfg_data;
		end
	end

	// receiver: random stalls, plus one long hold-off while requests pile up
	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				out_ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end
			out_ready <= quiet || ($urandom_range(99) >= 27);
		end
	end

	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < WatchdogLimit) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("%0t: no handshake for %0d cycles", $time, stalled);
		$display("Some tests failed");
		$finish;
	end

	task automatic push_sample(input logic [31:0] re, input logic [31:0] im, input logic lst,
			input logic typed, input search_result_t res);
		while (!quiet && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_real <= re;
		sample_imag <= im;
		last_sample <= lst;
		row_typed <= typed;
		row_result <= res;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		samples_sent++;
	endtask

	// drain all results, then let the pipeline empty; the first edge lets the
	// monitor log the final request before the queue is looked at
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_shift(input logic [cmes_pkg::ShiftW-1:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		shift_writes++;
	endtask

	function automatic logic [31:0] pick_component();
		logic [31:0] v;
		case ($urandom_range(9))
			0: v = 32'h0000_0000;
			1: v = 32'h8000_0000;
			2: v = 32'h7FFF_FFFF;
			3: v = 32'hFFFF_FFFF;
			4: v = $urandom_range(255);
			5: v = -$urandom_range(255);
			6: v = $urandom >> $urandom_range(31);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic int pick_length();
		case ($urandom_range(19))
			0: return $urandom_range(41, 120);
			1, 2, 3: return $urandom_range(9, 40);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	task automatic send_vector(input int len);
		logic [31:0] re;
		logic [31:0] im;
		logic [31:0] swap;
		re = '0;
		im = '0;
		for (int k = 0; k < len; k++) begin
			if (k > 0 && $urandom_range(99) < 20) begin
				// same energy as the previous sample
				if ($urandom_range(1)) begin
					swap = re;
					re = im;
					im = swap;
				end else
					re = -re;
			end else begin
				re = pick_component();
				im = pick_component();
			end
			push_sample(re, im, k == len - 1, 1'b0, '0);
		end
	endtask

	initial begin : stimulus
		int phase_start;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int r = 0; r < NumRows; r++) begin
			if (DirectedRows[r].kind == ROW_SHIFT)
				write_shift(DirectedRows[r].shift);
			else
				push_sample(DirectedRows[r].re, DirectedRows[r].im, DirectedRows[r].last,
					DirectedRows[r].typed, DirectedRows[r].result);
		end

		for (int p = 0; p < NumPhases; p++) begin
			case (p)
				1: begin
					write_shift('0);
					quiet <= 1'b1;
				end
				2: begin
					write_shift('1);
					quiet <= 1'b0;
				end
				3: begin
					write_shift(cmes_pkg::ShiftW'($urandom_range(24, 40)));
					hold_req <= 1'b1;
				end
				default: write_shift(cmes_pkg::ShiftW'($urandom_range(63)));
			endcase
			phase_start = samples_sent;
			while (samples_sent - phase_start < ItemsPerPhase)
				send_vector(pick_length());
		end

		settle();
		$display("Checked %0d results from %0d samples across %0d shift settings",
			results_checked, samples_sent, shift_writes);
		$display("with ties, extreme components, gaps, back-pressure and a long hold-off");
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
